/* hw/rtl/iaf_pkg.sv */
// ----------------------------------------------------------------------------
// iaf_pkg: shared types and constants of the integer to ASCII formatter
// Field widths, format codes, cell commands, sequencer states, digit glyphs.
// ----------------------------------------------------------------------------
`default_nettype none

package iaf_pkg;

  localparam int VALUE_W        = 64;
  localparam int FORMAT_W       = 2;
  localparam int MIN_WIDTH_W    = 6;
  localparam int CHAR_W         = 8;
  localparam int DIGIT_W        = 4;
  // Decimal digits of the widest 64-bit magnitude; hex needs only 16.
  localparam int NUM_CELLS      = 20;
  localparam int BUFFER_LEN_DEF = 36;

  localparam logic [FORMAT_W-1:0] FMT_SDEC = 2'd0;
  localparam logic [FORMAT_W-1:0] FMT_UDEC = 2'd1;
  localparam logic [FORMAT_W-1:0] FMT_HEX  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  localparam logic [CHAR_W-1:0] HEX_ASCII [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SHIFT,
    CELL_UP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     hex;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_PAD,
    ST_DIGIT
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/iaf_if.sv */
// ----------------------------------------------------------------------------
// iaf_if: valid/ready stream interfaces of the formatter
// Input beat carries one value to format; output beat carries one character.
// ----------------------------------------------------------------------------
`default_nettype none

interface iaf_in_if;
  import iaf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_W-1:0]     value;
  logic [FORMAT_W-1:0]    format;
  logic [MIN_WIDTH_W-1:0] min_width;

  modport source (output valid, output value, output format, output min_width,
                  input ready);
  modport sink   (input valid, input value, input format, input min_width,
                  output ready);
endinterface

interface iaf_out_if;
  import iaf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/integer_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 64-bit integer to decimal or hex ASCII
// Converts a value through a row of digit cells and streams its characters
// most significant first, with sign and zero padding.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Fields                        Beat
//   in_i     in   value, format, min_width      one value to format
//   out_o    out  character, last               one ASCII character
//
// Steps: one value is loaded, its 64 operand bits enter the cell row one per
// cycle, up to 19 leading zeros are dropped, and then sign, padding and digits
// are emitted, one character per cycle while the output is not stalled.
// Reset: asynchronous, active low; clears the sequencer state and output valid.
// Stalls: a waiting character holds in the output register; the next value is
// taken while the final character of the previous one still waits.
//
`default_nettype none

module integer_to_ascii_formatter #(
  parameter int BUFFER_LEN = iaf_pkg::BUFFER_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iaf_in_if.sink    in_i,
  iaf_out_if.source out_o
);
  import iaf_pkg::*;

  // Bit and digit links of the cell row. Cell 0 sits at the least significant
  // end; the shift bit enters there, digits move toward the top cell.
  logic               bit_w [NUM_CELLS];
  logic [DIGIT_W-1:0] dig_w [NUM_CELLS+1];
  cell_ctrl_t         cell_ctrl;
  logic               shift_bit;

  assign bit_w[0] = shift_bit;
  assign dig_w[0] = '0;

  // Sequencer: operand load, bit feed, leading-zero skip and character stream.
  iaf_seq #(
    .BUFFER_LEN (BUFFER_LEN)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .top_digit_i (dig_w[NUM_CELLS]),
    .shift_bit_o (shift_bit),
    .cell_ctrl_o (cell_ctrl)
  );

  // Row of digit cells; the top cell's carry has nowhere to go and stays open
  // (the row is wide enough that it never carries).
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == NUM_CELLS - 1) begin : g_top
      iaf_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl),
        .bit_i   (bit_w[k]),
        .digit_i (dig_w[k]),
        .bit_o   (),
        .digit_o (dig_w[k+1])
      );
    end else begin : g_mid
      iaf_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl),
        .bit_i   (bit_w[k]),
        .digit_i (dig_w[k]),
        .bit_o   (bit_w[k+1]),
        .digit_o (dig_w[k+1])
      );
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/iaf_cell.sv */
// ----------------------------------------------------------------------------
// iaf_cell: one digit cell of the conversion chain
// Shift-and-add-3 in decimal, plain nibble shift in hex, digit shift upward.
// ----------------------------------------------------------------------------
`default_nettype none

module iaf_cell (
  input  logic                        clk_i,
  input  iaf_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        bit_i,
  input  logic [iaf_pkg::DIGIT_W-1:0] digit_i,
  output logic                        bit_o,
  output logic [iaf_pkg::DIGIT_W-1:0] digit_o
);
  import iaf_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  // Correct a decimal digit before doubling so it carries at ten.
  assign adj   = (!ctrl_i.hex && (digit_q >= DIGIT_W'(5))) ? digit_q + DIGIT_W'(3) : digit_q;
  assign bit_o = adj[DIGIT_W-1];
  assign digit_o = digit_q;

  always_comb begin
    case (ctrl_i.op)
      CELL_HOLD:  digit_d = digit_q;
      CELL_CLEAR: digit_d = '0;
      CELL_SHIFT: digit_d = {adj[DIGIT_W-2:0], bit_i};
      CELL_UP:    digit_d = digit_i;
      default:    digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/iaf_seq.sv */
// ----------------------------------------------------------------------------
// iaf_seq: sequencer of the formatter
// Loads the magnitude, feeds its bits into the cell chain, then streams
// sign, padding and digits into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iaf_seq #(
  parameter int BUFFER_LEN = iaf_pkg::BUFFER_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  iaf_in_if.sink                      in_i,
  iaf_out_if.source                   out_o,
  input  logic [iaf_pkg::DIGIT_W-1:0] top_digit_i,
  output logic                        shift_bit_o,
  output iaf_pkg::cell_ctrl_t         cell_ctrl_o
);
  import iaf_pkg::*;

  localparam int DIGIT_CAP = BUFFER_LEN - 1;
  localparam int CW        = $clog2(BUFFER_LEN);
  localparam int RW        = $clog2(NUM_CELLS + 1);
  localparam int CMPW      = (CW > RW) ? CW : RW;
  localparam int SATW      = MIN_WIDTH_W + 1;
  localparam int BITCNT_W  = $clog2(VALUE_W);

  state_e              state_q, state_d;
  logic [VALUE_W-1:0]  mag_q, mag_d;
  logic [BITCNT_W-1:0] bitcnt_q, bitcnt_d;
  logic                hex_q, hex_d;
  logic                neg_q, neg_d;
  logic [CW-1:0]       pad_q, pad_d;
  logic [RW-1:0]       rem_q, rem_d;

  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic                out_last_q, out_last_d;

  logic                out_free;
  logic                in_neg;
  logic                in_hex;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_neg      = (in_i.format == FMT_SDEC) && in_i.value[VALUE_W-1];
  assign in_hex      = (in_i.format != FMT_SDEC) && (in_i.format != FMT_UDEC);
  assign shift_bit_o = mag_q[VALUE_W-1];

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bitcnt_d    = bitcnt_q;
    hex_d       = hex_q;
    neg_d       = neg_q;
    pad_d       = pad_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    cell_ctrl_o = '{op: CELL_HOLD, hex: hex_q};

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mag_d    = in_neg ? (VALUE_W'(0) - in_i.value) : in_i.value;
          hex_d    = in_hex;
          neg_d    = in_neg;
          bitcnt_d = '0;
          if (SATW'(in_i.min_width) > SATW'(DIGIT_CAP)) begin
            pad_d = CW'(DIGIT_CAP);
          end else begin
            pad_d = CW'(in_i.min_width);
          end
          cell_ctrl_o.op = CELL_CLEAR;
          state_d        = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl_o.op = CELL_SHIFT;
        mag_d          = {mag_q[VALUE_W-2:0], 1'b0};
        bitcnt_d       = bitcnt_q + BITCNT_W'(1);
        if (bitcnt_q == BITCNT_W'(VALUE_W - 1)) begin
          rem_d   = RW'(NUM_CELLS);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keep at least one digit.
        if ((rem_q > RW'(1)) && (top_digit_i == '0)) begin
          cell_ctrl_o.op = CELL_UP;
          rem_d          = rem_q - RW'(1);
        end else begin
          state_d = neg_q ? ST_SIGN : ST_PAD;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_PAD;
        end
      end
      ST_PAD: begin
        if (CMPW'(pad_q) > CMPW'(rem_q)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_char_d  = CHAR_ZERO;
            out_last_d  = 1'b0;
            pad_d       = pad_q - CW'(1);
          end
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_char_d     = HEX_ASCII[top_digit_i];
          out_last_d     = (rem_q == RW'(1));
          cell_ctrl_o.op = CELL_UP;
          rem_d          = rem_q - RW'(1);
          if (rem_q == RW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bitcnt_q   <= bitcnt_d;
    hex_q      <= hex_d;
    neg_q      <= neg_d;
    pad_q      <= pad_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/iaf_checker.sv */
// ----------------------------------------------------------------------------
// iaf_checker: port-level checks of the formatter
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module iaf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [iaf_pkg::CHAR_W-1:0] character_i,
  input logic                       last_i
);
  import iaf_pkg::*;

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(character_i) && $stable(last_i))
    else $error("stalled output beat changed");

  // Emit only sign or digit glyphs.
  a_out_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((character_i >= 8'h30) && (character_i <= 8'h39)) ||
                    ((character_i >= 8'h41) && (character_i <= 8'h46)) ||
                    (character_i == CHAR_MINUS))
    else $error("output character out of range");

  // The sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (character_i == CHAR_MINUS) |-> !last_i)
    else $error("sign flagged as last");

  // A taken value closes the input: ready falls after the accepting beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted during conversion");

endmodule

bind integer_to_ascii_formatter iaf_checker u_iaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .character_i (out_o.character),
  .last_i      (out_o.last)
);

`default_nettype wire
